[src/srd_pkg.sv]
package srd_pkg;

  // Field and register widths fixed by the interface
  localparam int RND_W     = 16;
  localparam int NUM_W     = 4;   // server_count register width
  localparam int WGT_W     = 8;
  localparam int WGT_N     = 8;   // weights carried by the weight register
  localparam int TOT_W     = 11;  // holds WGT_N * 255
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int OUT_SRV_W = 3;
  localparam int OUT_CNT_W = 32;
  localparam int OUT_TDATA_W = 40;

  localparam int QUEUE_DEPTH = 2;

  // Policy codes
  localparam logic [MODE_W-1:0] MODE_RR       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNIFORM  = 2'd2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS = 2'd2;

  localparam logic [CFG_W-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NUM_W-1:0]  count;
    logic [CFG_W-1:0]  weights;
  } srd_cfg_t;

  typedef struct packed {
    logic weight_error;
    logic batch_done;
  } srd_flags_t;

endpackage

[src/server_request_dispatcher.sv]
// Request dispatcher: picks a server for each incoming request and keeps
// a saturating per-server request count.
//
// Channels:
//   s_axis  - one request per beat: tdata = random_value, tlast = end of batch.
//   m_axis  - one result per request, in request order: chosen server and
//             its updated count in tdata, weight error flag in tuser,
//             tlast echoes the end-of-batch mark.
//   cfg     - register writes (index 0 policy, 1 server count, 2 weights);
//             always ready, issue only while no request is in flight.
// Front: takes one request at a time. Round robin goes straight to the
//   push state; uniform and weighted random first run the 16-step
//   remainder unit, and weighted random then adds a pick step.
// Path: front, two-entry queue, back counter update, output register;
//   a zero weight total skips the remainder unit.
// Reset: clears all counters (per-entry written bits), the rotate pointer
//   and registers to round robin, one server, all weights 1.
// Stall: a held result stays in the output register; the back stops, the
//   two-entry queue fills, then the front stops and drops s_axis_tready.
module server_request_dispatcher #(
  parameter int MAX_SERVERS = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] random_value
  input  logic        s_axis_tlast,   // end_of_batch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [2:0] chosen_server, [34:3] served_total, zero pad
  output logic [0:0]  m_axis_tuser,   // [0] weight_error
  output logic        m_axis_tlast,   // batch_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import srd_pkg::*;

  localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int Q_W   = SRV_W + $bits(srd_flags_t);

  srd_cfg_t cfg;

  // front -> queue
  logic             f_valid;
  logic             f_ready;
  logic [SRV_W-1:0] f_server;
  srd_flags_t       f_flags;

  // queue -> back
  logic             q_valid;
  logic             q_ready;
  logic [Q_W-1:0]   q_data;
  logic [SRV_W-1:0] q_server;
  srd_flags_t       q_flags;

  logic [OUT_SRV_W-1:0] o_server;
  logic [OUT_CNT_W-1:0] o_total;
  srd_flags_t           o_flags;

  // Config registers; unlisted indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_RR;
      cfg.count   <= NUM_W'(1);
      cfg.weights <= WEIGHTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:    cfg.mode    <= cfg_data[MODE_W-1:0];
        CFG_COUNT:   cfg.count   <= cfg_data[NUM_W-1:0];
        CFG_WEIGHTS: cfg.weights <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: policy decode, remainder unit, weight scan, rotate pointer
  srd_front #(
    .MAX_SERVERS(MAX_SERVERS),
    .SRV_W      (SRV_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_rnd     (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_server(f_server),
    .push_flags (f_flags)
  );

  srd_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_flags, f_server}),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  assign q_server = q_data[SRV_W-1:0];
  assign q_flags  = q_data[Q_W-1:SRV_W];

  // Back: counter memory update and output register
  srd_back #(
    .MAX_SERVERS(MAX_SERVERS),
    .SRV_W      (SRV_W),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_server(q_server),
    .pop_flags (q_flags),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_server(o_server),
    .out_total (o_total),
    .out_flags (o_flags)
  );

  assign m_axis_tdata = {5'b0, o_total, o_server};
  assign m_axis_tuser = o_flags.weight_error;
  assign m_axis_tlast = o_flags.batch_done;

endmodule

[src/srd_front.sv]
module srd_front #(
  parameter int MAX_SERVERS = 8,
  parameter int SRV_W       = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  srd_pkg::srd_cfg_t        cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [srd_pkg::RND_W-1:0] in_rnd,
  input  logic                     in_last,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [SRV_W-1:0]         push_server,
  output srd_pkg::srd_flags_t      push_flags
);
  import srd_pkg::*;

  localparam int CW = SRV_W + NUM_W;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV  = 4'b0010,
    F_PICK = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t state;
  logic [SRV_W-1:0] ptr;

  logic [RND_W-1:0] dividend;
  logic [TOT_W-1:0] rem;
  logic [TOT_W-1:0] divisor;
  logic [3:0]       step;
  logic             weighted;
  logic [SRV_W-1:0] server;
  srd_flags_t       flags;

  logic [NUM_W-1:0] n_used;
  logic [TOT_W-1:0] wlane [WGT_N];
  logic [TOT_W-1:0] prefix [WGT_N];
  logic [TOT_W-1:0] total;
  logic [SRV_W-1:0] pick;
  logic             found;
  logic [SRV_W-1:0] ptr_ok;
  logic [SRV_W-1:0] ptr_nxt;
  logic [TOT_W:0]   shifted;
  logic [TOT_W-1:0] rem_step;
  logic             is_weighted;
  logic             is_uniform;
  logic             accept;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state == F_IDLE);
  assign push_valid  = (state == F_PUSH);
  assign push_server = server;
  assign push_flags  = flags;

  assign is_weighted = (cfg.mode == MODE_WEIGHTED);
  assign is_uniform  = (cfg.mode == MODE_UNIFORM);

  // servers in use: zero reads as one, clipped at the build size
  always_comb begin
    if (cfg.count == '0) begin
      n_used = NUM_W'(1);
    end else if (int'(cfg.count) > MAX_SERVERS) begin
      n_used = NUM_W'(MAX_SERVERS);
    end else begin
      n_used = cfg.count;
    end
  end

  // running weight sums over the servers in use
  always_comb begin
    for (int i = 0; i < WGT_N; i++) begin
      wlane[i] = (NUM_W'(i) < n_used) ? TOT_W'(cfg.weights[i*WGT_W +: WGT_W]) : '0;
    end
    prefix[0] = wlane[0];
    for (int i = 1; i < WGT_N; i++) begin
      prefix[i] = prefix[i-1] + wlane[i];
    end
  end

  assign total = prefix[WGT_N-1];

  // first server whose running sum exceeds the remainder
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = 0; i < WGT_N; i++) begin
      if (!found && (rem < prefix[i])) begin
        pick  = SRV_W'(i);
        found = 1'b1;
      end
    end
  end

  // round robin pointer, wrapped if the server count was lowered
  assign ptr_ok  = (CW'(ptr) >= CW'(n_used)) ? '0 : ptr;
  assign ptr_nxt = ((CW'(ptr_ok) + CW'(1)) >= CW'(n_used)) ? '0 : ptr_ok + SRV_W'(1);

  // one restoring step of the remainder
  assign shifted = {rem, dividend[RND_W-1]};
  always_comb begin
    if (shifted >= {1'b0, divisor}) begin
      rem_step = TOT_W'(shifted - {1'b0, divisor});
    end else begin
      rem_step = shifted[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      ptr   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (in_last) begin
              ptr <= '0;
            end else if (!is_weighted && !is_uniform) begin
              ptr <= ptr_nxt;
            end
            if (is_weighted) begin
              state <= (total == '0) ? F_PUSH : F_DIV;
            end else if (is_uniform) begin
              state <= F_DIV;
            end else begin
              state <= F_PUSH;
            end
          end
        end
        F_DIV: begin
          if (step == '0) begin
            state <= weighted ? F_PICK : F_PUSH;
          end
        end
        F_PICK: state <= F_PUSH;
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          flags.batch_done   <= in_last;
          flags.weight_error <= is_weighted && (total == '0);
          dividend <= in_rnd;
          rem      <= '0;
          step     <= '1;
          weighted <= is_weighted;
          divisor  <= is_weighted ? total : TOT_W'(n_used);
          server   <= (is_weighted || is_uniform) ? '0 : ptr_ok;
        end
      end
      F_DIV: begin
        rem      <= rem_step;
        dividend <= dividend << 1;
        step     <= step - 4'd1;
        if (step == '0 && !weighted) begin
          server <= SRV_W'(rem_step);
        end
      end
      F_PICK: server <= pick;
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("front took a second request while busy");

endmodule

[src/srd_queue.sv]
module srd_queue #(
  parameter int WIDTH = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import srd_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_fill_tracks_push: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue fill level lost a push");

endmodule

[src/srd_back.sv]
module srd_back #(
  parameter int MAX_SERVERS = 8,
  parameter int SRV_W       = 3,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [SRV_W-1:0]              pop_server,
  input  srd_pkg::srd_flags_t           pop_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srd_pkg::OUT_SRV_W-1:0] out_server,
  output logic [srd_pkg::OUT_CNT_W-1:0] out_total,
  output srd_pkg::srd_flags_t           out_flags
);
  import srd_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_UPD  = 2'b10
  } back_state_t;

  back_state_t state;

  logic [COUNT_WIDTH-1:0] counts [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] written;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_written;
  logic [SRV_W-1:0]       cur_server;
  srd_flags_t             cur_flags;

  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   take;
  logic                   load_out;
  logic                   cnt_we;

  assign pop_ready = (state == B_IDLE);
  assign take      = pop_valid && pop_ready;
  assign load_out  = (state == B_UPD) && (!out_valid || out_ready);
  assign cnt_we    = load_out && !cur_flags.weight_error;

  // an entry never written since reset counts as zero
  assign cnt_cur = rd_written ? rd_data : '0;
  assign cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      written   <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (take) begin
            state <= B_UPD;
          end
        end
        B_UPD: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (cnt_we) begin
        written[cur_server] <= 1'b1;
      end
    end
  end

  // counter memory: one registered read and at most one write per request (none on a weight error)
  always_ff @(posedge clk) begin
    if (take) begin
      rd_data    <= counts[pop_server];
      rd_written <= written[pop_server];
      cur_server <= pop_server;
      cur_flags  <= pop_flags;
    end
    if (cnt_we) begin
      counts[cur_server] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_server <= OUT_SRV_W'(cur_server);
      out_total  <= cur_flags.weight_error ? '0 : OUT_CNT_W'(cnt_inc);
      out_flags  <= cur_flags;
    end
  end

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_flags.weight_error) |-> (out_total == '0 && out_server == '0))
    else $error("weight error result carries a server or count");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    ((state == B_UPD) && cur_flags.weight_error) |-> !cnt_we)
    else $error("counter written for a zero-weight request");

endmodule
